### hdl/vt100_subset_text_grid_assert.svh
// Assertion macros for the text grid block.
`ifndef VT100_SUBSET_TEXT_GRID_ASSERT_SVH
`define VT100_SUBSET_TEXT_GRID_ASSERT_SVH

// Checked only outside reset.
`define VT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define VT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/vt_pkg.sv
package vt_pkg;

  localparam int ROWS   = 55;
  localparam int COLS   = 110;
  localparam int MAX_PARAM_CHARS = 63;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = 6;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 7;

  typedef logic [ADDR_W-1:0] vt_addr_t;
  typedef logic [ROW_W-1:0]  vt_row_t;
  typedef logic [COL_W-1:0]  vt_col_t;
  typedef logic [CHAR_W-1:0] vt_char_t;

  localparam vt_char_t SPACE     = 7'd32;
  localparam vt_addr_t LAST_ADDR = vt_addr_t'(CELLS - 1);

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUT,
    OP_CLEAR,
    OP_ERASE
  } vt_op_kind_t;

  typedef struct packed {
    vt_op_kind_t kind;
    vt_addr_t    addr;      // cursor cell: write target or erase start
    vt_addr_t    erase_end; // last cell of the cursor row
    vt_char_t    ch;
  } vt_op_t;

  typedef struct packed {
    vt_row_t row;
    vt_col_t col;
  } vt_cursor_t;

endpackage

### hdl/vt_ram.sv
module vt_ram #(
  parameter int WIDTH  = 7,
  parameter int DEPTH  = 6050,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/vt_parse.sv
module vt_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  output vt_pkg::vt_cursor_t cur,
  output vt_pkg::vt_cursor_t cur_next,
  output vt_pkg::vt_op_t     op
);

  typedef enum logic [2:0] {
    PH_TEXT    = 3'd0,
    PH_ESC     = 3'd1,
    PH_CSI     = 3'd2,
    PH_OSC     = 3'd3,
    PH_OSC_ESC = 3'd4
  } phase_t;

  localparam logic [7:0] C_BEL   = 8'h07;
  localparam logic [7:0] C_BS    = 8'h08;
  localparam logic [7:0] C_LF    = 8'h0A;
  localparam logic [7:0] C_CR    = 8'h0D;
  localparam logic [7:0] C_ESC   = 8'h1B;
  localparam logic [7:0] C_SPACE = 8'h20;
  localparam logic [7:0] C_TILDE = 8'h7E;
  localparam logic [7:0] C_ZERO  = 8'h30;
  localparam logic [7:0] C_NINE  = 8'h39;
  localparam logic [7:0] C_SEMI  = 8'h3B;
  localparam logic [7:0] C_QUEST = 8'h3F;
  localparam logic [7:0] C_LBRK  = 8'h5B;
  localparam logic [7:0] C_RBRK  = 8'h5D;
  localparam logic [7:0] C_BSL   = 8'h5C;
  localparam logic [7:0] CMD_A   = 8'h41;
  localparam logic [7:0] CMD_B   = 8'h42;
  localparam logic [7:0] CMD_C   = 8'h43;
  localparam logic [7:0] CMD_D   = 8'h44;
  localparam logic [7:0] CMD_H   = 8'h48;
  localparam logic [7:0] CMD_J   = 8'h4A;
  localparam logic [7:0] CMD_K   = 8'h4B;
  localparam logic [7:0] CMD_F   = 8'h66;

  localparam logic [1:0] NF_FIRST  = 2'd0;
  localparam logic [1:0] NF_SECOND = 2'd1;
  localparam logic [1:0] NF_DONE   = 2'd2;

  localparam logic [5:0] PLEN_MAX  = 6'(vt_pkg::MAX_PARAM_CHARS);
  localparam logic [7:0] ROWS8     = 8'(vt_pkg::ROWS);
  localparam logic [7:0] COLS8     = 8'(vt_pkg::COLS);
  localparam logic [8:0] ROWS9     = 9'(vt_pkg::ROWS);
  localparam logic [8:0] COLS9     = 9'(vt_pkg::COLS);
  localparam vt_pkg::vt_row_t LAST_ROW = vt_pkg::vt_row_t'(vt_pkg::ROWS - 1);
  localparam vt_pkg::vt_col_t LAST_COL = vt_pkg::vt_col_t'(vt_pkg::COLS - 1);
  localparam vt_pkg::vt_col_t COLS_C   = vt_pkg::vt_col_t'(vt_pkg::COLS);

  phase_t     phase, phase_next;
  logic [5:0] plen, plen_next;
  logic [7:0] fnum, fnum_next;
  logic [7:0] snum, snum_next;
  logic [1:0] nf, nf_next;
  logic       fhd, fhd_next;

  vt_pkg::vt_addr_t row_base;
  logic       is_digit;
  logic [7:0] amt;
  logic [7:0] hrow;
  logic [7:0] hcol;
  logic [8:0] sum;

  function automatic logic [7:0] add_digit(input logic [7:0] acc, input logic [3:0] d);
    logic [11:0] v;
    v = {4'b0, acc} * 12'd10 + {8'b0, d};
    return (v > 12'd255) ? 8'd255 : v[7:0];
  endfunction

  assign row_base      = vt_pkg::vt_addr_t'(cur.row) * vt_pkg::vt_addr_t'(vt_pkg::COLS);
  assign op.addr       = row_base + vt_pkg::vt_addr_t'(cur.col);
  assign op.erase_end  = row_base + vt_pkg::vt_addr_t'(vt_pkg::COLS - 1);
  assign op.ch         = data_byte[6:0];
  assign is_digit      = (data_byte >= C_ZERO) && (data_byte <= C_NINE);
  assign amt           = (plen == 6'd0) ? 8'd1 : (fhd ? fnum : 8'd0);
  assign hrow          = ((fhd ? fnum : 8'd0) > 8'd0) ? fnum - 8'd1 : 8'd0;
  assign hcol          = (snum > 8'd0) ? snum - 8'd1 : 8'd0;

  always_comb begin
    phase_next = phase;
    plen_next  = plen;
    fnum_next  = fnum;
    snum_next  = snum;
    nf_next    = nf;
    fhd_next   = fhd;
    cur_next   = cur;
    op.kind    = vt_pkg::OP_NONE;
    sum        = '0;
    if (step) begin
      unique case (phase)
        PH_ESC: begin
          if (data_byte == C_LBRK) begin
            phase_next = PH_CSI;
            plen_next  = '0;
            fnum_next  = '0;
            snum_next  = '0;
            nf_next    = NF_FIRST;
            fhd_next   = 1'b0;
          end else if (data_byte == C_RBRK) begin
            phase_next = PH_OSC;
          end else begin
            phase_next = PH_TEXT;
          end
        end
        PH_CSI: begin
          if (plen < PLEN_MAX &&
              (data_byte == C_SEMI || data_byte == C_QUEST || is_digit)) begin
            plen_next = plen + 6'd1;
            if (is_digit) begin
              if (nf == NF_FIRST) begin
                fnum_next = add_digit(fnum, data_byte[3:0]);
                fhd_next  = 1'b1;
              end else if (nf == NF_SECOND) begin
                snum_next = add_digit(snum, data_byte[3:0]);
              end
            end else if (data_byte == C_SEMI && nf == NF_FIRST && fhd) begin
              nf_next = NF_SECOND;
            end else begin
              nf_next = NF_DONE;
            end
          end else begin
            phase_next = PH_TEXT;
            unique case (data_byte) inside
              CMD_H, CMD_F: begin
                cur_next.row = (hrow >= ROWS8) ? LAST_ROW : hrow[vt_pkg::ROW_W-1:0];
                cur_next.col = (hcol >= COLS8) ? LAST_COL : hcol[vt_pkg::COL_W-1:0];
              end
              CMD_J: op.kind = vt_pkg::OP_CLEAR;
              CMD_K: begin
                if (cur.col < COLS_C) op.kind = vt_pkg::OP_ERASE;
              end
              CMD_A: begin
                cur_next.row = (amt >= 8'(cur.row)) ? '0
                             : cur.row - amt[vt_pkg::ROW_W-1:0];
              end
              CMD_B: begin
                sum = 9'(cur.row) + 9'(amt);
                cur_next.row = (sum >= ROWS9) ? LAST_ROW : sum[vt_pkg::ROW_W-1:0];
              end
              CMD_C: begin
                sum = 9'(cur.col) + 9'(amt);
                cur_next.col = (sum >= COLS9) ? LAST_COL : sum[vt_pkg::COL_W-1:0];
              end
              CMD_D: begin
                cur_next.col = (amt >= 8'(cur.col)) ? '0
                             : cur.col - amt[vt_pkg::COL_W-1:0];
              end
              default: ;
            endcase
          end
        end
        PH_OSC_ESC: begin
          if (data_byte == C_BSL || data_byte == C_BEL) phase_next = PH_TEXT;
          else if (data_byte == C_ESC) phase_next = PH_OSC_ESC;
          else phase_next = PH_OSC;
        end
        PH_OSC: begin
          if (data_byte == C_BEL) phase_next = PH_TEXT;
          else if (data_byte == C_ESC) phase_next = PH_OSC_ESC;
        end
        default: begin
          if (data_byte == C_ESC) begin
            phase_next = PH_ESC;
          end else if (data_byte == C_CR) begin
            cur_next.col = '0;
          end else if (data_byte == C_LF) begin
            cur_next.col = '0;
            cur_next.row = (cur.row >= LAST_ROW) ? LAST_ROW : cur.row + 1'b1;
          end else if (data_byte == C_BS) begin
            if (cur.col != '0) cur_next.col = cur.col - 1'b1;
          end else if (data_byte >= C_SPACE && data_byte <= C_TILDE && cur.col < COLS_C) begin
            op.kind      = vt_pkg::OP_PUT;
            cur_next.col = cur.col + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TEXT;
      plen  <= '0;
      fnum  <= '0;
      snum  <= '0;
      nf    <= NF_FIRST;
      fhd   <= 1'b0;
      cur   <= '0;
    end else begin
      phase <= phase_next;
      plen  <= plen_next;
      fnum  <= fnum_next;
      snum  <= snum_next;
      nf    <= nf_next;
      fhd   <= fhd_next;
      cur   <= cur_next;
    end
  end

endmodule

### hdl/vt100_subset_text_grid.sv
// Text grid for a VT100 byte stream, 55 rows by 110 columns, held in one
// single-port RAM. A terminal byte's result word is registered on the edge
// that takes the byte; a cell read waits in a read state for the registered
// RAM output. After reset the grid is swept to spaces with input held off.
// An ESC[J sweeps the whole grid again and ESC[K sweeps the rest of the
// cursor row from the cursor column on; during a sweep the result word is
// already out but no new byte is taken. The sweep writes one cell per cycle
// through the RAM port.
`include "vt100_subset_text_grid_assert.svh"

module vt100_subset_text_grid (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [7:0]                  data_byte,
  input  logic [vt_pkg::ROW_W-1:0]    read_row,
  input  logic [vt_pkg::COL_W-1:0]    read_col,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vt_pkg::CHAR_W-1:0]   cell_char,
  output logic [vt_pkg::ROW_W-1:0]    cursor_row,
  output logic [vt_pkg::COL_W-1:0]    cursor_col
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SWEEP
  } state_t;

  localparam vt_pkg::vt_row_t ROWS_R = vt_pkg::vt_row_t'(vt_pkg::ROWS);
  localparam vt_pkg::vt_col_t COLS_R = vt_pkg::vt_col_t'(vt_pkg::COLS);

  state_t             state;
  vt_pkg::vt_addr_t   sweep_addr;
  vt_pkg::vt_addr_t   sweep_end;
  logic               read_hit;

  logic               accept;
  logic               step;
  logic               read_ok;
  vt_pkg::vt_addr_t   read_addr;
  vt_pkg::vt_cursor_t cur;
  vt_pkg::vt_cursor_t cur_next;
  vt_pkg::vt_op_t     op;

  logic               ram_we;
  vt_pkg::vt_addr_t   ram_addr;
  vt_pkg::vt_char_t   ram_wdata;
  vt_pkg::vt_char_t   ram_rdata;

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign step      = accept && !mode;
  assign read_ok   = (read_row < ROWS_R) && (read_col < COLS_R);
  assign read_addr = vt_pkg::vt_addr_t'(read_row) * vt_pkg::vt_addr_t'(vt_pkg::COLS)
                   + vt_pkg::vt_addr_t'(read_col);

  vt_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (data_byte),
    .cur       (cur),
    .cur_next  (cur_next),
    .op        (op)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = read_addr;
    ram_wdata = op.ch;
    if (state == S_SWEEP) begin
      ram_we    = 1'b1;
      ram_addr  = sweep_addr;
      ram_wdata = vt_pkg::SPACE;
    end else if (step && op.kind == vt_pkg::OP_PUT) begin
      ram_we   = 1'b1;
      ram_addr = op.addr;
    end
  end

  vt_ram #(
    .WIDTH  (vt_pkg::CHAR_W),
    .DEPTH  (vt_pkg::CELLS),
    .ADDR_W (vt_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      sweep_end  <= vt_pkg::LAST_ADDR;
      out_valid  <= 1'b0;
      read_hit   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (mode) begin
              // the pending word, if any, leaves on this edge
              out_valid <= 1'b0;
              state     <= S_READ;
              read_hit  <= read_ok;
            end else begin
              out_valid  <= 1'b1;
              cell_char  <= vt_pkg::SPACE;
              cursor_row <= cur_next.row;
              cursor_col <= cur_next.col;
              if (op.kind == vt_pkg::OP_CLEAR) begin
                state      <= S_SWEEP;
                sweep_addr <= '0;
                sweep_end  <= vt_pkg::LAST_ADDR;
              end else if (op.kind == vt_pkg::OP_ERASE) begin
                state      <= S_SWEEP;
                sweep_addr <= op.addr;
                sweep_end  <= op.erase_end;
              end
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          out_valid  <= 1'b1;
          cell_char  <= read_hit ? ram_rdata : vt_pkg::SPACE;
          cursor_row <= cur.row;
          cursor_col <= cur.col;
          state      <= S_IDLE;
        end
        S_SWEEP: begin
          if (out_ready) out_valid <= 1'b0;
          if (sweep_addr == sweep_end) state <= S_IDLE;
          else sweep_addr <= sweep_addr + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `VT_ASSERT(a_sweep_bounded, (state == S_SWEEP) |-> (sweep_addr <= sweep_end), "sweep overran its end")
  `VT_ASSERT(a_read_to_out, (accept && mode) |=> (state == S_READ && !out_valid), "read did not wait for RAM")
  `VT_ASSERT(a_read_done, (state == S_READ) |=> (out_valid && state == S_IDLE), "read word not delivered")
  `VT_ASSERT(a_no_write_in_read, (state == S_READ) |-> !ram_we, "RAM written during a read")
  `VT_ASSERT_ALWAYS(a_cursor_range, out_valid |-> (cursor_row < ROWS_R), "cursor row out of range")

endmodule
